// File: src/robot_packet_checksum_verify_core_macros.svh
// Assertion macros for the packet checksum verifier.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ROBOT_PACKET_CHECKSUM_VERIFY_CORE_MACROS_SVH
`define ROBOT_PACKET_CHECKSUM_VERIFY_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RPCV_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rpcv: implication check failed");
// next-cycle implication
`define RPCV_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rpcv: next-cycle check failed");
`else
`define RPCV_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RPCV_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: src/rpcv_pkg.sv
// Shared constants and result type for the packet checksum verifier.
// No dependencies.
package rpcv_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 512;
    localparam int LEN_POS              = 2;
    localparam int ID_POS               = 3;
    localparam int MIN_PACKET_BYTES     = 6;
    localparam int OUT_DATA_W           = 32;

    // packed low to high: checksum_ok, too_short, computed_sum, packet_id
    typedef struct packed {
        logic [7:0]  packet_id;
        logic [15:0] computed_sum;
        logic        too_short;
        logic        checksum_ok;
    } rpcv_result_t;

endpackage

// File: src/robot_packet_checksum_verify_core.sv
// Packet checksum verifier: per-byte 16-bit word sum and trailer compare.
// Depends on rpcv_pkg and robot_packet_checksum_verify_core_macros.svh.
// An accepted last byte passes the input register, then the result register.
// Throughput: one byte per cycle while the result output is not stalled.
// Reset: asynchronous, clears the packet state and both valid flags.
`include "robot_packet_checksum_verify_core_macros.svh"

module robot_packet_checksum_verify_core #(
    parameter int MAX_PACKET_BYTES = rpcv_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [rpcv_pkg::OUT_DATA_W-1:0] m_axis_tdata
    // m_axis_tdata: [0] checksum_ok, [1] too_short, [17:2] computed_sum,
    //               [25:18] packet_id, [31:26] zero
);
    import rpcv_pkg::*;

    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam int CMP_W = POS_W + 8;
    localparam logic [POS_W-1:0] POS_MAX   = POS_W'(MAX_PACKET_BYTES);
    localparam logic [POS_W-1:0] POS_LEN   = POS_W'(LEN_POS);
    localparam logic [POS_W-1:0] POS_ID    = POS_W'(ID_POS);
    localparam logic [POS_W-1:0] POS_SHORT = POS_W'(MIN_PACKET_BYTES - 1);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // packet state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       count_reg, count_next;
    logic [15:0]      sum_reg, sum_next;
    logic [7:0]       held_reg, held_next;
    logic             pend_reg, pend_next;
    logic [7:0]       prev_reg, prev_next;
    logic [7:0]       id_reg, id_next;

    // result register
    logic         res_valid_reg;
    rpcv_result_t res_reg, res_next;

    logic             advance;
    logic [CMP_W-1:0] pos_ext, cnt_ext;
    logic             in_region, word_open;
    logic [7:0]       id_cur;
    logic [15:0]      sum_cur, sum_final, trailer;
    logic             short_pkt;

    assign advance       = in_valid_reg && (!res_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(res_reg);

    assign pos_ext   = {8'd0, pos_reg};
    assign cnt_ext   = {{POS_W{1'b0}}, count_reg};
    assign in_region = (pos_reg >= POS_ID) && (pos_reg < POS_MAX) && (pos_ext <= cnt_ext);
    assign word_open = pos_ext < cnt_ext;

    always_comb
    begin
        count_next = (pos_reg == POS_LEN) ? in_byte_reg : count_reg;
        id_cur     = (pos_reg == POS_ID) ? in_byte_reg : id_reg;
        sum_cur    = sum_reg;
        held_next  = held_reg;
        pend_next  = pend_reg;
        if (in_region)
        begin
            if (pend_reg)
            begin
                sum_cur   = sum_reg + {held_reg, in_byte_reg};
                pend_next = 1'b0;
                held_next = 8'd0;
            end
            else if (word_open)
            begin
                held_next = in_byte_reg;
                pend_next = 1'b1;
            end
            else
            begin
                sum_cur = sum_reg ^ {8'd0, in_byte_reg};
            end
        end

        sum_final = pend_next ? (sum_cur + {held_next, 8'd0}) : sum_cur;
        trailer   = {prev_reg, in_byte_reg};
        short_pkt = pos_reg < POS_SHORT;

        res_next.checksum_ok  = !short_pkt && (sum_final == trailer);
        res_next.too_short    = short_pkt;
        res_next.computed_sum = sum_final;
        res_next.packet_id    = (pos_reg >= POS_ID) ? id_cur : 8'd0;

        if (in_last_reg)
        begin
            pos_next   = '0;
            count_next = 8'd0;
            sum_next   = 16'd0;
            held_next  = 8'd0;
            pend_next  = 1'b0;
            prev_next  = 8'd0;
            id_next    = 8'd0;
        end
        else
        begin
            pos_next  = (pos_reg < POS_MAX) ? pos_reg + 1'b1 : pos_reg;
            sum_next  = sum_cur;
            prev_next = in_byte_reg;
            id_next   = id_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            pos_reg       <= '0;
            count_reg     <= 8'd0;
            sum_reg       <= 16'd0;
            held_reg      <= 8'd0;
            pend_reg      <= 1'b0;
            prev_reg      <= 8'd0;
            id_reg        <= 8'd0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
            begin
                pos_reg   <= pos_next;
                count_reg <= count_next;
                sum_reg   <= sum_next;
                held_reg  <= held_next;
                pend_reg  <= pend_next;
                prev_reg  <= prev_next;
                id_reg    <= id_next;
            end
            if (advance)
                res_valid_reg <= in_last_reg;
            else if (m_axis_tready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance && in_last_reg)
            res_reg <= res_next;
    end

    `RPCV_ASSERT_IMP(a_pend_after_id, clk, rst_n, pend_reg, pos_reg > POS_ID)
    `RPCV_ASSERT_NXT(a_clear_on_last, clk, rst_n, advance && in_last_reg,
        pos_reg == '0 && !pend_reg && sum_reg == 16'd0)
    `RPCV_ASSERT_IMP(a_short_not_ok, clk, rst_n, res_valid_reg && res_reg.too_short,
        !res_reg.checksum_ok)
    `RPCV_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid_reg && !advance,
        in_valid_reg && $stable(in_byte_reg))

endmodule
